// ----- sv/rctp_pkg.sv -----
// shared constants, entry record and a saturating time add for the timer pool
package rctp_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 48;
  localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int IDX_W    = 4;
  localparam int NOW_W    = 48;
  localparam int PERIOD_W = 32;
  localparam int COUNT_W  = 16;
  localparam int DELAY_W  = 32;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;

  localparam logic [COUNT_W-1:0] INFINITE_CALLS = '1;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_SET    = 2'd1,
    KIND_START  = 2'd2,
    KIND_STOP   = 2'd3
  } kind_e;

  typedef struct packed {
    logic                enabled;
    logic [COUNT_W-1:0]  calls_left;
    logic [COUNT_W-1:0]  calls_init;
    time_t               due;
    logic [PERIOD_W-1:0] period;
  } timer_rec_t;

  localparam int REC_W = $bits(timer_rec_t);

  // saturating add of a 32 bit offset to a time value
  function automatic time_t sat_add(time_t a, logic [PERIOD_W-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS + 1)'(b);
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

endpackage

// ----- sv/repeat_count_timer_pool_unit.sv -----
// pool of indexed repeat-count timers, state held in one entry ram
//
// input channel s_axis: tuser carries the kind (update, set, start, stop),
// tdata the index, current time, period, repeat count and start delay.
// output channel m_axis: one item per firing, tdata the timer index,
// tuser the exhausted flag, tlast marks the final firing of an update.
// set, start and stop read the entry, then write the modified entry
// back. an update accepts the item, streams every entry through the
// ram read pipeline in turn, then releases the held-back last firing.
// one firing is held back until the next is found so tlast can be set;
// while that holding stage is full, the current entry fires and the
// output register is full and not being taken, the scan holds its
// place and re-reads the same entry.
// after reset every entry reads as zero through per-entry valid flops,
// so no clearing pass is needed; the output register empties.
// the next input item is taken once the flush step is done, even while
// a result still waits in the output register.
module repeat_count_timer_pool_unit
  import rctp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // timer_index, now_time, period, repeat_count, start_delay, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fired_timer, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // exhausted
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e state_q;

  // latched input item
  kind_e               kind_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                oob_q;
  time_t               now_q;
  logic [PERIOD_W-1:0] per_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [DELAY_W-1:0]  delay_q;

  logic [ADDR_W-1:0] scan_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [NUM_TIMERS-1:0] valid_q;

  // held-back firing and output register
  logic             pend_v_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             pend_ex_q;
  logic             out_v_q;
  logic             out_v_d;
  logic             out_load;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_ex_q;
  logic             out_last_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  timer_rec_t        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REC_W-1:0]  ram_rdata;

  timer_rec_t ent;
  timer_rec_t scan_rec;
  timer_rec_t cmd_rec;
  logic       has_calls;
  logic       fire;
  logic [COUNT_W-1:0] new_left;
  logic       fire_ex;
  logic       out_free;
  logic       advance;
  logic       s_accept;
  logic       last_entry;

  rctp_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign last_entry    = (scan_q == ADDR_W'(NUM_TIMERS - 1));

  // an entry never written reads as its reset value
  assign ent = valid_q[rd_addr_q] ? timer_rec_t'(ram_rdata) : '0;

  always_comb begin
    has_calls = (ent.calls_init == INFINITE_CALLS) ||
                ((ent.calls_left != '0) && !ent.calls_left[COUNT_W-1]);
    fire      = ent.enabled && has_calls && !(ent.due > now_q);
    new_left  = (ent.calls_init == INFINITE_CALLS) ? ent.calls_left
                                                   : ent.calls_left - 1'b1;
    fire_ex   = (new_left == '0);

    scan_rec            = ent;
    scan_rec.calls_left = new_left;
    scan_rec.enabled    = !fire_ex;
    if (!fire_ex) begin
      scan_rec.due = sat_add(now_q, ent.period);
    end

    cmd_rec = ent;
    case (kind_q)
      KIND_SET: begin
        cmd_rec.period     = per_q;
        cmd_rec.calls_left = cnt_q;
        cmd_rec.calls_init = cnt_q;
        cmd_rec.enabled    = 1'b0;
      end
      KIND_START: begin
        if (!ent.enabled) begin
          cmd_rec.enabled    = 1'b1;
          cmd_rec.calls_left = ent.calls_init;
          cmd_rec.due        = sat_add(now_q, delay_q);
        end
      end
      KIND_STOP: cmd_rec.enabled = 1'b0;
      default: ;
    endcase
  end

  // scan moves on unless a firing has nowhere to go
  assign advance = !fire || !pend_v_q || out_free;

  // the held-back firing moves into the output register
  assign out_load = ((state_q == ST_SCAN) && advance && fire && pend_v_q) ||
                    ((state_q == ST_FLUSH) && pend_v_q && out_free);
  assign out_v_d  = out_load || (out_v_q && !m_axis_tready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = cmd_rec;
    ram_raddr = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = (kind_e'(s_axis_tuser) == KIND_UPDATE) ? '0
                                                            : ADDR_W'(s_axis_tdata[IDX_W-1:0]);
      end
      ST_CMD: begin
        ram_we = !oob_q;
      end
      ST_SCAN: begin
        ram_waddr = scan_q;
        ram_wdata = scan_rec;
        ram_we    = fire && advance;
        ram_raddr = advance ? scan_q + 1'b1 : scan_q;
      end
      ST_FLUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= ram_raddr;
    if (s_accept) begin
      kind_q  <= kind_e'(s_axis_tuser);
      addr_q  <= ADDR_W'(s_axis_tdata[IDX_W-1:0]);
      oob_q   <= 32'(s_axis_tdata[IDX_W-1:0]) >= NUM_TIMERS;
      now_q   <= time_t'(s_axis_tdata[IDX_W +: NOW_W]);
      per_q   <= s_axis_tdata[IDX_W+NOW_W +: PERIOD_W];
      cnt_q   <= s_axis_tdata[IDX_W+NOW_W+PERIOD_W +: COUNT_W];
      delay_q <= s_axis_tdata[IDX_W+NOW_W+PERIOD_W+COUNT_W +: DELAY_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      scan_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            scan_q  <= '0;
            state_q <= (kind_e'(s_axis_tuser) == KIND_UPDATE) ? ST_SCAN : ST_CMD;
          end
        end
        ST_CMD: begin
          state_q <= ST_IDLE;
        end
        ST_SCAN: begin
          if (advance) begin
            if (fire) begin
              if (pend_v_q) begin
                out_idx_q  <= pend_idx_q;
                out_ex_q   <= pend_ex_q;
                out_last_q <= 1'b0;
              end
              pend_v_q   <= 1'b1;
              pend_idx_q <= IDX_W'(scan_q);
              pend_ex_q  <= fire_ex;
            end
            scan_q <= scan_q + 1'b1;
            if (last_entry) begin
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_idx_q  <= pend_idx_q;
            out_ex_q   <= pend_ex_q;
            out_last_q <= 1'b1;
            pend_v_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_idx_q);
  assign m_axis_tuser  = out_ex_q;
  assign m_axis_tlast  = out_last_q;

  // no firing is left behind once the block takes a new item
  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("held-back firing left over after update");

  // the ram is written only by a command or the scan
  a_we_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CMD || state_q == ST_SCAN))
    else $error("entry write outside command or scan");

  // a stalled scan holds its place
  a_scan_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !advance) |=> (state_q == ST_SCAN && $stable(scan_q)))
    else $error("scan moved while a firing was blocked");

  // a held-back firing is not lost while the output is busy
  a_pend_keep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_v_q && !out_free) |=> pend_v_q)
    else $error("held-back firing dropped");

endmodule

// ----- sv/rctp_ram.sv -----
// generic single write port ram with one registered read port
module rctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
